@@ src/qte_pkg.sv @@
// Shared types, constants and helper functions for the quaternion to
// Euler angle pipeline. No dependencies.
`default_nettype none

package qte_pkg;

    localparam int IN_W     = 16;
    localparam int CFG_W    = 15;
    localparam int PITCH_W  = 15;
    localparam int YAW_W    = 16;
    localparam int ROLL_W   = 17;
    localparam int CASE_W   = 2;

    // datapath widths
    localparam int PROD_W   = 32;   // 16x16 products
    localparam int VEC_W    = 34;   // matrix numerators and vectoring inputs
    localparam int PQ_W     = 33;   // clamped sqrt factors
    localparam int RAD_W    = 64;   // radicand of the square root
    localparam int XY_W     = 44;   // vectoring x/y after normalisation
    localparam int MAG_W    = 42;   // magnitude tracked while normalising
    localparam int ACC_W    = 46;   // angle accumulator, 2^-40 rad
    localparam int RND_W    = 48;   // rounding headroom

    localparam int SQRT_STEPS   = 32;
    localparam int NORM_STEPS   = 6;
    localparam int CORDIC_STEPS = 40;
    localparam int CORDIC_LAT   = 1 + NORM_STEPS + 1 + CORDIC_STEPS;

    localparam logic signed [ACC_W-1:0] PI_Q40      = 46'sh3243F6A8886;
    localparam logic signed [ACC_W-1:0] QUARTER_PI  = 46'sh00C90FDAA221;
    localparam logic [CFG_W-1:0]        MARGIN_RESET = 15'd16;
    localparam logic [CFG_W-1:0]        ONE_Q14     = 15'd16384;
    localparam logic signed [PITCH_W-1:0] PITCH_POLE = 15'sd12868;

    typedef enum logic [CASE_W-1:0] {
        CASE_REGULAR = 2'd0,
        CASE_SOUTH   = 2'd1,
        CASE_NORTH   = 2'd2
    } pole_case_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] ns;
        logic signed [VEC_W-1:0] m10;
        logic signed [VEC_W-1:0] m00;
        logic signed [VEC_W-1:0] ry;
        logic signed [VEC_W-1:0] rx;
    } side_t;

    // arctangent of 2^-i in units of 2^-40 rad, series form, elaboration only
    function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
        logic signed [RND_W-1:0] sum;
        logic [RND_W-1:0]        num;
        logic [RND_W-1:0]        quo;
        logic [RND_W-1:0]        rem;
        int                      p;
        int                      d;
        if (idx == 0)
        begin
            return QUARTER_PI;
        end
        sum = '0;
        for (int k = 0; k < 21; k++)
        begin
            p = idx * (2 * k + 1);
            if (p <= 40)
            begin
                num = RND_W'(1) << (40 - p);
                d   = 2 * k + 1;
                quo = '0;
                rem = '0;
                // shift-subtract long division
                for (int b = RND_W - 1; b >= 0; b--)
                begin
                    rem = {rem[RND_W-2:0], num[b]};
                    if (rem >= RND_W'(d))
                    begin
                        rem    = rem - RND_W'(d);
                        quo[b] = 1'b1;
                    end
                end
                if ((k & 1) != 0)
                    sum = sum - signed'(quo);
                else
                    sum = sum + signed'(quo);
            end
        end
        return sum[ACC_W-1:0];
    endfunction

    // 2^-40 rad to Q3.13, halves round up
    function automatic logic signed [20:0] to_q13(input logic signed [RND_W-1:0] a);
        logic signed [RND_W-1:0] t;
        t = a + 48'sd67108864;
        return t[RND_W-1:27];
    endfunction

endpackage

`default_nettype wire

@@ src/qte_if.sv @@
// Request and result channel interfaces for the quaternion to Euler pipeline.
// Depends on qte_pkg.
`default_nettype none

interface qte_quat_if;
    logic                              valid;
    logic                              ready;
    logic signed [qte_pkg::IN_W-1:0]   quat_w;
    logic signed [qte_pkg::IN_W-1:0]   quat_x;
    logic signed [qte_pkg::IN_W-1:0]   quat_y;
    logic signed [qte_pkg::IN_W-1:0]   quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

interface qte_euler_if;
    logic                               valid;
    logic                               ready;
    logic signed [qte_pkg::PITCH_W-1:0] pitch_angle;
    logic signed [qte_pkg::YAW_W-1:0]   yaw_angle;
    logic signed [qte_pkg::ROLL_W-1:0]  roll_angle;
    logic [qte_pkg::CASE_W-1:0]         pole_case;

    modport source (output valid, output pitch_angle, output yaw_angle,
                    output roll_angle, output pole_case, input ready);
    modport sink   (input valid, input pitch_angle, input yaw_angle,
                    input roll_angle, input pole_case, output ready);
endinterface

`default_nettype wire

@@ src/qte_cordic.sv @@
// Pipelined atan2 kernel: normalise, fold into the right half plane, then
// 40 vectoring stages. Depends on qte_pkg.
`default_nettype none

module qte_cordic (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [qte_pkg::VEC_W-1:0]   y_in,
    input  wire logic signed [qte_pkg::VEC_W-1:0]   x_in,
    output logic signed [qte_pkg::ACC_W-1:0]        angle
);

    localparam int NS = qte_pkg::NORM_STEPS;
    localparam int CS = qte_pkg::CORDIC_STEPS;

    logic signed [qte_pkg::XY_W-1:0]  nx_reg   [0:NS];
    logic signed [qte_pkg::XY_W-1:0]  ny_reg   [0:NS];
    logic [qte_pkg::MAG_W-1:0]        nmag_reg [0:NS];
    logic                             nz_reg   [0:NS];

    logic signed [qte_pkg::XY_W-1:0]  rx_reg   [0:CS];
    logic signed [qte_pkg::XY_W-1:0]  ry_reg   [0:CS];
    logic signed [qte_pkg::ACC_W-1:0] racc_reg [0:CS];
    logic                             rz_reg   [0:CS];

    logic [qte_pkg::VEC_W-1:0] ax_next;
    logic [qte_pkg::VEC_W-1:0] ay_next;

    always_comb
    begin
        ax_next = (x_in < 0) ? unsigned'(-x_in) : unsigned'(x_in);
        ay_next = (y_in < 0) ? unsigned'(-y_in) : unsigned'(y_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg[0]   <= qte_pkg::XY_W'(x_in);
            ny_reg[0]   <= qte_pkg::XY_W'(y_in);
            nmag_reg[0] <= qte_pkg::MAG_W'((ax_next > ay_next) ? ax_next : ay_next);
            nz_reg[0]   <= (x_in == '0) && (y_in == '0);
        end
    end

    // binary normalisation: leaves the larger magnitude in [2^40, 2^41)
    for (genvar j = 1; j <= NS; j++)
    begin : g_norm
        localparam int SH = 1 << (NS - j);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nz_reg[j] <= nz_reg[j-1];
                if ((nmag_reg[j-1] >> (qte_pkg::MAG_W - 1 - SH)) == '0)
                begin
                    nx_reg[j]   <= nx_reg[j-1] <<< SH;
                    ny_reg[j]   <= ny_reg[j-1] <<< SH;
                    nmag_reg[j] <= nmag_reg[j-1] << SH;
                end
                else
                begin
                    nx_reg[j]   <= nx_reg[j-1];
                    ny_reg[j]   <= ny_reg[j-1];
                    nmag_reg[j] <= nmag_reg[j-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rz_reg[0] <= nz_reg[NS];
            if (nx_reg[NS] < 0)
            begin
                rx_reg[0]   <= -nx_reg[NS];
                ry_reg[0]   <= -ny_reg[NS];
                racc_reg[0] <= (ny_reg[NS] >= 0) ? qte_pkg::PI_Q40 : -qte_pkg::PI_Q40;
            end
            else
            begin
                rx_reg[0]   <= nx_reg[NS];
                ry_reg[0]   <= ny_reg[NS];
                racc_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 1; i <= CS; i++)
    begin : g_rot
        localparam logic signed [qte_pkg::ACC_W-1:0] T_K = qte_pkg::atan_entry(i - 1);
        logic signed [qte_pkg::XY_W-1:0] xs;
        logic signed [qte_pkg::XY_W-1:0] ys;

        assign xs = rx_reg[i-1] >>> (i - 1);
        assign ys = ry_reg[i-1] >>> (i - 1);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rz_reg[i] <= rz_reg[i-1];
                if (ry_reg[i-1] > 0)
                begin
                    rx_reg[i]   <= rx_reg[i-1] + ys;
                    ry_reg[i]   <= ry_reg[i-1] - xs;
                    racc_reg[i] <= racc_reg[i-1] + T_K;
                end
                else
                begin
                    rx_reg[i]   <= rx_reg[i-1] - ys;
                    ry_reg[i]   <= ry_reg[i-1] + xs;
                    racc_reg[i] <= racc_reg[i-1] - T_K;
                end
            end
        end
    end

    assign angle = rz_reg[CS] ? '0 : racc_reg[CS];

endmodule

`default_nettype wire

@@ src/quaternion_to_euler_angles_top.sv @@
// Quaternion to Z-Y-X Euler angle pipeline, top level.
// Depends on qte_pkg, qte_if (qte_quat_if, qte_euler_if) and qte_cordic.
//
// Usage:
//   quat  : request channel, one quaternion (Q1.14, any length) per request.
//   euler : result channel, pitch/yaw/roll Q1.13/Q2.13/Q3.13 rad, pole case.
//   cfg_we/cfg_wdata : writes the pole margin (units of 2^-14); write it only
//   while the pipeline is empty.
// Throughput: one request per cycle, sustained unless the result stalls.
// Pipeline: products, sums and pole test, the sqrt radicand, the
//   one-bit-per-stage square root that gives the pitch cosine, the atan2
//   pipelines (entry, 6 normalise, fold, 40 vectoring stages), all three
//   angles running in parallel, then the result register.
// Stall: quat.ready = !euler.valid | euler.ready; when the result register
//   holds an untaken result the whole pipeline freezes and nothing is lost.
// Reset: valid bits clear, the margin returns to 16; no results pending.
`default_nettype none

module quaternion_to_euler_angles_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [qte_pkg::CFG_W-1:0]        cfg_wdata,
    qte_quat_if.sink                              quat,
    qte_euler_if.source                           euler
);

    localparam int VW       = qte_pkg::VEC_W;
    localparam int SQ       = qte_pkg::SQRT_STEPS;
    localparam int PIPE_LEN = 3 + (SQ + 1) + qte_pkg::CORDIC_LAT;
    localparam int LAST     = PIPE_LEN - 1;

    logic                         en;
    logic [qte_pkg::CFG_W-1:0]    margin_reg;

    logic                         vpipe_reg [0:LAST];
    qte_pkg::pole_case_t          cpipe_reg [2:LAST];

    // stage 1
    logic signed [qte_pkg::PROD_W-1:0] wsq_reg, xsq_reg, ysq_reg, zsq_reg;
    logic signed [qte_pkg::PROD_W-1:0] yw_reg, xz_reg, xy_reg, zw_reg, yz_reg, xw_reg;
    logic signed [qte_pkg::IN_W-1:0]   w1_reg, z1_reg;
    // stage 2
    logic signed [VW-1:0] s_reg, n_reg, m00_reg, m10_reg, m21_reg, m22_reg;
    logic signed [qte_pkg::IN_W-1:0]   w2_reg, z2_reg;
    // stage 3
    logic [qte_pkg::PQ_W-1:0]          p_reg, q_reg;
    qte_pkg::side_t                    side3_reg;
    // radicand and square root stages
    logic [qte_pkg::RAD_W-1:0]         sqv_reg [0:SQ];
    logic [qte_pkg::RAD_W-1:0]         sqr_reg [0:SQ];
    qte_pkg::side_t                    side_reg [0:SQ];

    // stage 3 combinational
    logic signed [16:0]                kfac_next;
    logic signed [47:0]                lhs_next;
    logic signed [50:0]                rhs_next;
    logic                              south_next, north_next;
    qte_pkg::pole_case_t               case_next;
    logic signed [VW-1:0]              ns_next, ds_next;
    logic signed [VW:0]                pd_next, qd_next;
    logic [2*qte_pkg::PQ_W-1:0]        pq_next;

    // kernels
    logic signed [qte_pkg::ACC_W-1:0]  pitch_ang, yaw_ang, roll_ang;
    logic signed [VW-1:0]              cos_val;

    // result
    logic                              out_valid_reg;
    logic signed [qte_pkg::PITCH_W-1:0] pitch_reg, pitch_next;
    logic signed [qte_pkg::YAW_W-1:0]   yaw_reg, yaw_next;
    logic signed [qte_pkg::ROLL_W-1:0]  roll_reg, roll_next;
    qte_pkg::pole_case_t                case_reg;
    logic signed [20:0]                 roll_q13;

    assign en         = !out_valid_reg || euler.ready;
    assign quat.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            margin_reg <= qte_pkg::MARGIN_RESET;
        else if (cfg_we)
            margin_reg <= cfg_wdata;
    end

    for (genvar i = 0; i < PIPE_LEN; i++)
    begin : g_valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vpipe_reg[i] <= 1'b0;
            else if (en)
                vpipe_reg[i] <= (i == 0) ? quat.valid : vpipe_reg[(i == 0) ? 0 : i - 1];
        end
    end

    for (genvar i = 3; i < PIPE_LEN; i++)
    begin : g_case
        always_ff @(posedge clk)
        begin
            if (en)
                cpipe_reg[i] <= cpipe_reg[i-1];
        end
    end

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wsq_reg <= quat.quat_w * quat.quat_w;
            xsq_reg <= quat.quat_x * quat.quat_x;
            ysq_reg <= quat.quat_y * quat.quat_y;
            zsq_reg <= quat.quat_z * quat.quat_z;
            yw_reg  <= quat.quat_y * quat.quat_w;
            xz_reg  <= quat.quat_x * quat.quat_z;
            xy_reg  <= quat.quat_x * quat.quat_y;
            zw_reg  <= quat.quat_z * quat.quat_w;
            yz_reg  <= quat.quat_y * quat.quat_z;
            xw_reg  <= quat.quat_x * quat.quat_w;
            w1_reg  <= quat.quat_w;
            z1_reg  <= quat.quat_z;
        end
    end

    // stage 2: matrix numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= VW'(wsq_reg) + VW'(xsq_reg) + VW'(ysq_reg) + VW'(zsq_reg);
            n_reg   <= (VW'(yw_reg) - VW'(xz_reg)) <<< 1;
            m00_reg <= VW'(wsq_reg) + VW'(xsq_reg) - VW'(ysq_reg) - VW'(zsq_reg);
            m10_reg <= (VW'(xy_reg) + VW'(zw_reg)) <<< 1;
            m21_reg <= (VW'(yz_reg) + VW'(xw_reg)) <<< 1;
            m22_reg <= VW'(wsq_reg) - VW'(xsq_reg) - VW'(ysq_reg) + VW'(zsq_reg);
            w2_reg  <= w1_reg;
            z2_reg  <= z1_reg;
        end
    end

    // stage 3: pole test against the margin, sqrt factors
    always_comb
    begin
        kfac_next = 17'sd16384 - signed'({2'b00, margin_reg});
        lhs_next  = {n_reg, 14'b0};
        rhs_next  = kfac_next * s_reg;
        if (s_reg == '0)
        begin
            south_next = margin_reg > qte_pkg::ONE_Q14;
            north_next = 1'b0;
        end
        else
        begin
            south_next = lhs_next > rhs_next;
            north_next = lhs_next < -rhs_next;
        end
        if (south_next)
            case_next = qte_pkg::CASE_SOUTH;
        else if (north_next)
            case_next = qte_pkg::CASE_NORTH;
        else
            case_next = qte_pkg::CASE_REGULAR;

        if (s_reg >= 34'sd2147483648)
        begin
            ns_next = n_reg >>> 2;
            ds_next = s_reg >>> 2;
        end
        else
        begin
            ns_next = n_reg;
            ds_next = s_reg;
        end
        pd_next = (VW+1)'(ds_next) - (VW+1)'(ns_next);
        qd_next = (VW+1)'(ds_next) + (VW+1)'(ns_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cpipe_reg[2]  <= case_next;
            p_reg         <= (pd_next < 0) ? '0 : unsigned'(pd_next[qte_pkg::PQ_W-1:0]);
            q_reg         <= (qd_next < 0) ? '0 : unsigned'(qd_next[qte_pkg::PQ_W-1:0]);
            side3_reg.ns  <= ns_next;
            side3_reg.m10 <= m10_reg;
            side3_reg.m00 <= m00_reg;
            if (case_next != qte_pkg::CASE_REGULAR)
            begin
                side3_reg.ry <= VW'(z2_reg);
                side3_reg.rx <= VW'(w2_reg);
            end
            else
            begin
                side3_reg.ry <= m21_reg;
                side3_reg.rx <= m22_reg;
            end
        end
    end

    // stage 4: radicand P*Q
    assign pq_next = p_reg * q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqv_reg[0]  <= pq_next[qte_pkg::RAD_W-1:0];
            sqr_reg[0]  <= '0;
            side_reg[0] <= side3_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar i = 1; i <= SQ; i++)
    begin : g_sqrt
        localparam int B = SQ - i;
        logic [qte_pkg::RAD_W-1:0] bitv;
        logic [qte_pkg::RAD_W-1:0] trial;

        assign bitv  = qte_pkg::RAD_W'(1) << (2 * B);
        assign trial = sqr_reg[i-1] + bitv;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i] <= side_reg[i-1];
                if (sqv_reg[i-1] >= trial)
                begin
                    sqv_reg[i] <= sqv_reg[i-1] - trial;
                    sqr_reg[i] <= (sqr_reg[i-1] >> 1) + bitv;
                end
                else
                begin
                    sqv_reg[i] <= sqv_reg[i-1];
                    sqr_reg[i] <= sqr_reg[i-1] >> 1;
                end
            end
        end
    end

    assign cos_val = signed'({2'b00, sqr_reg[SQ][31:0]});

    qte_cordic u_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (side_reg[SQ].ns),
        .x_in  (cos_val),
        .angle (pitch_ang)
    );

    qte_cordic u_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (side_reg[SQ].m10),
        .x_in  (side_reg[SQ].m00),
        .angle (yaw_ang)
    );

    qte_cordic u_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (side_reg[SQ].ry),
        .x_in  (side_reg[SQ].rx),
        .angle (roll_ang)
    );

    // result formatting
    always_comb
    begin
        pitch_next = '0;
        yaw_next   = '0;
        roll_q13   = qte_pkg::to_q13(qte_pkg::RND_W'(roll_ang));
        case (cpipe_reg[LAST])
            qte_pkg::CASE_SOUTH:
            begin
                pitch_next = qte_pkg::PITCH_POLE;
                roll_q13   = qte_pkg::to_q13(-(qte_pkg::RND_W'(roll_ang) <<< 1));
            end
            qte_pkg::CASE_NORTH:
            begin
                pitch_next = -qte_pkg::PITCH_POLE;
                roll_q13   = qte_pkg::to_q13(qte_pkg::RND_W'(roll_ang) <<< 1);
            end
            default:
            begin
                pitch_next = qte_pkg::to_q13(qte_pkg::RND_W'(pitch_ang))
                             [qte_pkg::PITCH_W-1:0];
                yaw_next   = qte_pkg::to_q13(qte_pkg::RND_W'(yaw_ang))
                             [qte_pkg::YAW_W-1:0];
            end
        endcase
        roll_next = roll_q13[qte_pkg::ROLL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vpipe_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            roll_reg  <= roll_next;
            case_reg  <= cpipe_reg[LAST];
        end
    end

    assign euler.valid       = out_valid_reg;
    assign euler.pitch_angle = pitch_reg;
    assign euler.yaw_angle   = yaw_reg;
    assign euler.roll_angle  = roll_reg;
    assign euler.pole_case   = case_reg;

endmodule

`default_nettype wire

@@ src/qte_checker.sv @@
// Port-level checks for the quaternion to Euler pipeline, bound to the top.
// Depends on qte_pkg and quaternion_to_euler_angles_top.
`default_nettype none

module qte_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_ready,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic signed [qte_pkg::PITCH_W-1:0]  pitch_angle,
    input  wire logic signed [qte_pkg::YAW_W-1:0]    yaw_angle,
    input  wire logic [qte_pkg::CASE_W-1:0]          pole_case
);

    // a result must not vanish while the receiver stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped during stall");

    // requests are only refused while a result is stalled
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("request ready inconsistent with result stall");

    a_south: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pole_case == qte_pkg::CASE_SOUTH |->
            pitch_angle == qte_pkg::PITCH_POLE && yaw_angle == '0)
        else $error("positive pole result malformed");

    a_north: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pole_case == qte_pkg::CASE_NORTH |->
            pitch_angle == -qte_pkg::PITCH_POLE && yaw_angle == '0)
        else $error("negative pole result malformed");

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (quat.ready),
    .out_valid   (euler.valid),
    .out_ready   (euler.ready),
    .pitch_angle (euler.pitch_angle),
    .yaw_angle   (euler.yaw_angle),
    .pole_case   (euler.pole_case)
);

`default_nettype wire
